// ===== rtl/core/bsc_pkg.sv =====
`timescale 1ns / 1ps
package bsc_pkg;

  // ascii pad character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // one decoded-or-encoded burst of up to four results
  typedef struct packed {
    logic [3:0][7:0] ch;
    logic [1:0]      last_idx;
    logic            eos;
    logic            nd;
  } job_t;

  // sextet to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'd71 + {2'b00, s};
    end else if (s < 6'd62) begin
      r = {2'b00, s} - 8'd4;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // character to {valid, sextet}
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      d = c - 8'd65;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      d = c - 8'd71;
      r = {1'b1, d[5:0]};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      d = c + 8'd4;
      r = {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/base64_stream_codec.sv =====
`timescale 1ns / 1ps
// base64 stream codec, standard alphabet
// input channel: push/full with in_char and in_last; one byte or character
//   per transaction, in_last marks the end of a stream
// result channel: empty/pop with out_char, out_end_of_stream, out_no_data;
//   the oldest result waits on the ports while empty is low
// config: apb-style port, register 0 is mode (0 encode, 1 decode); writing
//   it drops any partial group; write it only while the block is idle
// path: a result passes through the burst queue, the burst register and the
//   output register; the front stage is combinational
// throughput: the back end emits one result per cycle while the receiver pops;
//   a two-entry burst queue lets the front keep accepting while results wait
// a stalled receiver fills the output register, the burst register, then
//   the queue, and full rises; nothing is lost
// reset clears mode to encode and empties the stream state and queue
module base64_stream_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        out_end_of_stream,
  output logic        out_no_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          acc, cfg_wr, mode;
  logic          job_wr, q_rd, q_full, q_empty;
  bsc_pkg::job_t job, q_data;

  assign pready = 1'b1;
  assign full   = q_full;
  assign acc    = push && !q_full;

  // register 0 decode
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode} : 32'd0;

  bsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_char  (in_char),
    .in_last  (in_last),
    .cfg_wr   (cfg_wr),
    .cfg_mode (pwdata[0]),
    .mode     (mode),
    .job_wr   (job_wr),
    .job      (job)
  );

  bsc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (job_wr),
    .wr_data (job),
    .rd      (q_rd),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  bsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_rd              (q_rd),
    .pop               (pop),
    .empty             (empty),
    .out_char          (out_char),
    .out_end_of_stream (out_end_of_stream),
    .out_no_data       (out_no_data)
  );

endmodule

// ===== rtl/core/bsc_front.sv =====
`timescale 1ns / 1ps
module bsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        in_char,
  input  logic              in_last,
  input  logic              cfg_wr,
  input  logic              cfg_mode,
  output logic              mode,
  output logic              job_wr,
  output bsc_pkg::job_t     job
);

  bsc_pkg::mode_t mode_r;
  logic [23:0]    gb_r, gb_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pad_r, pad_nxt;

  logic [23:0] enc_gb, dec_gb, g_al;
  logic [2:0]  nchar;
  logic [1:0]  nbyte_m1;
  logic        emit_enc, emit_dec;
  logic [6:0]  sx;

  assign mode = mode_r;
  assign enc_gb = {gb_r[15:0], in_char};
  assign sx = bsc_pkg::dec_sextet(in_char);
  assign dec_gb = {gb_r[17:0], sx[5:0]};

  // group update and burst build
  always_comb begin
    gb_nxt   = gb_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    emit_enc = 1'b0;
    emit_dec = 1'b0;
    g_al     = 24'd0;
    nchar    = 3'd4;
    nbyte_m1 = 2'd0;
    if (mode_r == bsc_pkg::MODE_ENCODE) begin
      if (cnt_r == 2'd2) begin
        emit_enc = 1'b1;
        g_al     = enc_gb;
        gb_nxt   = 24'd0;
        cnt_nxt  = 2'd0;
      end else begin
        gb_nxt  = enc_gb;
        cnt_nxt = cnt_r + 2'd1;
        if (in_last) begin
          emit_enc = 1'b1;
          if (cnt_r == 2'd0) begin
            g_al  = {in_char, 16'd0};
            nchar = 3'd2;
          end else begin
            g_al  = {enc_gb[15:0], 8'd0};
            nchar = 3'd3;
          end
        end
      end
    end else if (!pad_r) begin
      if (in_char == bsc_pkg::PAD_CHAR) begin
        if (cnt_r == 2'd2) begin
          emit_dec = 1'b1;
          g_al     = {gb_r[11:0], 12'd0};
          nbyte_m1 = 2'd0;
        end else if (cnt_r == 2'd3) begin
          emit_dec = 1'b1;
          g_al     = {gb_r[17:0], 6'd0};
          nbyte_m1 = 2'd1;
        end
        gb_nxt  = 24'd0;
        cnt_nxt = 2'd0;
        pad_nxt = 1'b1;
      end else if (sx[6]) begin
        if (cnt_r == 2'd3) begin
          emit_dec = 1'b1;
          g_al     = dec_gb;
          nbyte_m1 = 2'd2;
          gb_nxt   = 24'd0;
          cnt_nxt  = 2'd0;
        end else begin
          gb_nxt  = dec_gb;
          cnt_nxt = cnt_r + 2'd1;
        end
      end
    end
    // stream end clears the group, count and pad state
    if (in_last) begin
      gb_nxt  = 24'd0;
      cnt_nxt = 2'd0;
      pad_nxt = 1'b0;
    end
  end

  // burst descriptor
  always_comb begin
    job = '0;
    if (emit_enc) begin
      for (int i = 0; i < 4; i++) begin
        job.ch[i] = (3'(i) < nchar) ? bsc_pkg::enc_char(g_al[23-6*i -: 6])
                                    : bsc_pkg::PAD_CHAR;
      end
    end else if (emit_dec) begin
      // at most three bytes per decoded group
      for (int i = 0; i < 3; i++) begin
        job.ch[i] = g_al[23-8*i -: 8];
      end
    end
    job.last_idx = emit_enc ? 2'd3 : nbyte_m1;
    job.eos      = in_last;
    job.nd       = in_last && !emit_enc && !emit_dec;
    if (job.nd) begin
      job.last_idx = 2'd0;
    end
  end

  assign job_wr = acc && (emit_enc || emit_dec || in_last);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsc_pkg::MODE_ENCODE;
      gb_r   <= 24'd0;
      cnt_r  <= 2'd0;
      pad_r  <= 1'b0;
    end else if (cfg_wr) begin
      mode_r <= bsc_pkg::mode_t'(cfg_mode);
      gb_r   <= 24'd0;
      cnt_r  <= 2'd0;
      pad_r  <= 1'b0;
    end else if (acc) begin
      gb_r  <= gb_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

endmodule

// ===== rtl/core/bsc_fifo.sv =====
`timescale 1ns / 1ps
module bsc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  bsc_pkg::job_t wr_data,
  input  logic          rd,
  output bsc_pkg::job_t rd_data,
  output logic          q_full,
  output logic          q_empty
);

  localparam int unsigned PW = $clog2(bsc_pkg::QUEUE_DEPTH);

  bsc_pkg::job_t mem [bsc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == (PW+1)'(bsc_pkg::QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/bsc_back.sv =====
`timescale 1ns / 1ps
module bsc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  bsc_pkg::job_t q_data,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_char,
  output logic          out_end_of_stream,
  output logic          out_no_data
);

  bsc_pkg::job_t cur_r;
  logic          cur_v_r;
  logic [1:0]    idx_r;
  logic          out_v_r;
  logic [7:0]    out_char_r;
  logic          eos_r, nd_r;
  logic          load_out, cur_done, cur_free;

  assign load_out = cur_v_r && (!out_v_r || pop);
  assign cur_done = load_out && (idx_r == cur_r.last_idx);
  assign cur_free = !cur_v_r || cur_done;
  assign q_rd     = cur_free && !q_empty;

  assign empty             = !out_v_r;
  assign out_char          = out_char_r;
  assign out_end_of_stream = eos_r;
  assign out_no_data       = nd_r;

  // current burst and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (q_rd) begin
      cur_v_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (cur_done) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load_out) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= cur_r.ch[idx_r];
      eos_r      <= cur_r.eos && (idx_r == cur_r.last_idx);
      nd_r       <= cur_r.nd;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (idx_r <= cur_r.last_idx))
    else $error("result index past end of burst");

  a_nd_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && nd_r) |-> (eos_r && out_char_r == 8'd0))
    else $error("empty result does not close the stream");

  a_fetch_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> (!cur_v_r || cur_done))
    else $error("burst fetched over a live one");

  a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && pop && !cur_v_r) |=> !out_v_r)
    else $error("taken result not retired");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam logic [2:0]  ADDR_MODE     = 3'd0;
  localparam logic [2:0]  ADDR_SPARE    = 3'd4;
  localparam int unsigned TARGET_ITEMS  = 470;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned PRESSURE_LEN  = 40;

  // one expected result transaction
  typedef struct {
    logic [7:0] ch;
    logic       eos;
    logic       nd;
  } b64_out_t;

  // tracks the codec state and the characters or bytes still owed by the dut
  class base64_checker;
    bsc_pkg::mode_t mode;
    logic [23:0]    group_bits;
    logic [1:0]     group_count;
    bit             pad_seen;
    b64_out_t       due_chars[$];
    int unsigned    errors;
    int unsigned    n_encode;
    int unsigned    n_decode;
    int unsigned    n_checked;
    int unsigned    n_closes;

    function new();
      mode = bsc_pkg::MODE_ENCODE;
      errors = 0;
      n_encode = 0;
      n_decode = 0;
      n_checked = 0;
      n_closes = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      group_bits = '0;
      group_count = '0;
      pad_seen = 1'b0;
    endfunction

    function void set_mode(logic [31:0] v);
      mode = bsc_pkg::mode_t'(v[0]);
      clear_stream();
    endfunction

    // sextet to alphabet character
    static function logic [7:0] sextet_char(int s);
      if (s < 26) return 8'h41 + 8'(s);
      if (s < 52) return 8'h61 + 8'(s - 26);
      if (s < 62) return 8'h30 + 8'(s - 52);
      if (s == 62) return 8'h2B;
      return 8'h2F;
    endfunction

    // alphabet character to sextet, -1 when outside the alphabet
    static function int char_sextet(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      return -1;
    endfunction

    function void owe(logic [7:0] ch);
      b64_out_t r;
      r.ch = ch;
      r.eos = 1'b0;
      r.nd = 1'b0;
      due_chars.push_back(r);
    endfunction

    // top-aligned group to nchars characters, padded to four
    function void owe_chars(logic [23:0] g, int nchars);
      for (int i = 0; i < 4; i++) begin
        if (i < nchars) owe(sextet_char(int'((g >> (18 - 6 * i)) & 24'h3F)));
        else owe(bsc_pkg::PAD_CHAR);
      end
    endfunction

    // top-aligned group to nbytes bytes
    function void owe_bytes(logic [23:0] g, int nbytes);
      for (int i = 0; i < nbytes; i++) owe(8'((g >> (16 - 8 * i)) & 24'hFF));
    endfunction

    // returns 1 when the transaction did more than get skipped
    function bit take_input(logic [7:0] c, logic l);
      int          before_n;
      int          s;
      bit          used;
      logic [23:0] g;
      b64_out_t    close_r;
      before_n = due_chars.size();
      used = l;
      if (mode == bsc_pkg::MODE_ENCODE) begin
        n_encode++;
        used = 1'b1;
        group_bits = {group_bits[15:0], c};
        if (group_count == 2'd2) begin
          owe_chars(group_bits, 4);
          group_bits = '0;
          group_count = '0;
        end else begin
          group_count++;
        end
        if (l) begin
          if (group_count == 2'd1) begin
            g = group_bits << 16;
            owe_chars(g, 2);
          end else if (group_count == 2'd2) begin
            g = group_bits << 8;
            owe_chars(g, 3);
          end
        end
      end else begin
        n_decode++;
        if (!pad_seen) begin
          s = char_sextet(c);
          if (c == bsc_pkg::PAD_CHAR) begin
            used = 1'b1;
            if (group_count == 2'd2) begin
              g = group_bits << 12;
              owe_bytes(g, 1);
            end else if (group_count == 2'd3) begin
              g = group_bits << 6;
              owe_bytes(g, 2);
            end
            group_bits = '0;
            group_count = '0;
            pad_seen = 1'b1;
          end else if (s >= 0) begin
            used = 1'b1;
            group_bits = {group_bits[17:0], 6'(s)};
            if (group_count == 2'd3) begin
              owe_bytes(group_bits, 3);
              group_bits = '0;
              group_count = '0;
            end else begin
              group_count++;
            end
          end
        end
      end
      // end of stream: mark the last result or add a close-only result
      if (l) begin
        if (due_chars.size() == before_n) begin
          close_r.ch = 8'h00;
          close_r.eos = 1'b1;
          close_r.nd = 1'b1;
          due_chars.push_back(close_r);
        end else begin
          due_chars[due_chars.size() - 1].eos = 1'b1;
        end
        clear_stream();
      end
      return used;
    endfunction

    function void check_output(logic [7:0] ch, logic eos, logic nd);
      b64_out_t e;
      if (due_chars.size() == 0) begin
        $error("unexpected result: out_char %h eos %b no_data %b", ch, eos, nd);
        errors++;
        return;
      end
      e = due_chars.pop_front();
      n_checked++;
      if (e.nd) n_closes++;
      if (ch !== e.ch) begin
        $error("out_char: expected %h, got %h", e.ch, ch);
        errors++;
      end
      if (eos !== e.eos) begin
        $error("out_end_of_stream: expected %b, got %b", e.eos, eos);
        errors++;
      end
      if (nd !== e.nd) begin
        $error("out_no_data: expected %b, got %b", e.nd, nd);
        errors++;
      end
    endfunction

    function int pending();
      return due_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_char;
  logic        in_last;
  logic        empty;
  logic        pop;
  logic [7:0]  out_char;
  logic        out_end_of_stream;
  logic        out_no_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  base64_checker tracker;
  bit            hold_off;
  int unsigned   accepted;
  int unsigned   counted;

  base64_stream_codec dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_char           (in_char),
    .in_last           (in_last),
    .empty             (empty),
    .pop               (pop),
    .out_char          (out_char),
    .out_end_of_stream (out_end_of_stream),
    .out_no_data       (out_no_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one input transaction, recorded at the edge that accepts it
  task automatic send_item(input logic [7:0] c, input logic l);
    push <= 1'b1;
    in_char <= c;
    in_last <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    accepted++;
    if (tracker.take_input(c, l)) counted++;
  endtask

  task automatic sender_gap(input bit calm);
    int n;
    n = calm ? 0 : pick_gap();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_stream(input logic [7:0] q[$], input bit calm);
    for (int i = 0; i < q.size(); i++) begin
      send_item(q[i], i == q.size() - 1);
      sender_gap(calm);
    end
  endtask

  // wait until every owed result is back, then let the pipeline go quiet
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MODE) tracker.set_mode(data);
    // leave the bus idle before the next transaction
    @(posedge clk);
  endtask

  task automatic check_mode_reg();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MODE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'd0, tracker.mode}) begin
      $error("prdata: expected %h, got %h", {31'd0, tracker.mode}, prdata);
      tracker.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random raw bytes for encoding, sometimes all zero or all ones
  task automatic random_encode_stream(input int n, input bit calm);
    logic [7:0] q[$];
    int         kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if (kind == 0) q.push_back(8'h00);
      else if (kind == 1) q.push_back(8'hFF);
      else q.push_back(8'($urandom_range(0, 255)));
    end
    send_stream(q, calm);
  endtask

  // mostly well-formed text with padding, some noise and broken sequences
  task automatic random_decode_stream(input bit calm);
    logic [7:0] q[$];
    int         n;
    int         rem;
    if ($urandom_range(0, 99) < 75) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 8) q.push_back(8'($urandom_range(0, 255)));
        q.push_back(base64_checker::sextet_char($urandom_range(0, 63)));
      end
      rem = n % 4;
      if (rem == 2) begin
        q.push_back(bsc_pkg::PAD_CHAR);
        q.push_back(bsc_pkg::PAD_CHAR);
      end else if (rem == 3 || (rem == 1 && $urandom_range(0, 1) == 1)) begin
        q.push_back(bsc_pkg::PAD_CHAR);
      end else if (rem == 0 && $urandom_range(0, 4) == 0) begin
        q.push_back(bsc_pkg::PAD_CHAR);
      end
      // junk after the end of the text
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 15) q.push_back(bsc_pkg::PAD_CHAR);
        else q.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_stream(q, calm);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall_left;
    int          r;
    stall_left = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) tracker.check_output(out_char, out_end_of_stream, out_no_data);
      if (hold_off) begin
        hold_off = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 12) stall_left = $urandom_range(1, 3);
        else if (r < 15) stall_left = $urandom_range(10, 40);
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] q[$];
    int         phase;
    int         phase_start;
    bit         calm;
    tracker = new();
    hold_off = 1'b0;
    accepted = 0;
    counted = 0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_char <= 8'h00;
    in_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MODE;
    pwdata <= 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_mode_reg();

    // encode: lone zero byte, two ones bytes, full group ending the stream
    q = '{8'h00};
    send_stream(q, 1'b0);
    q = '{8'hFF, 8'hFF};
    send_stream(q, 1'b0);
    q = '{8'h4D, 8'h61, 8'h6E};
    send_stream(q, 1'b1);
    // partial group left open, then dropped by the mode write
    q = '{8'h80, 8'h01};
    foreach (q[i]) send_item(q[i], 1'b0);
    drain();
    cfg_write(ADDR_MODE, 32'(bsc_pkg::MODE_DECODE));
    check_mode_reg();
    // decode: two pads in a row, the second one closing the stream
    q = '{8'h54, 8'h57, 8'h45, bsc_pkg::PAD_CHAR, bsc_pkg::PAD_CHAR};
    send_stream(q, 1'b0);
    // pad after a single sextet, then ignored text
    q = '{8'h54, bsc_pkg::PAD_CHAR, 8'h78};
    send_stream(q, 1'b0);
    // skipped noise inside a full group
    q = '{8'h2F, 8'h2F, 8'h2A, 8'h38, 8'h41};
    send_stream(q, 1'b1);
    // pad with nothing gathered
    q = '{bsc_pkg::PAD_CHAR};
    send_stream(q, 1'b0);
    // unpadded partial group at the end is dropped
    q = '{8'h51, 8'h51};
    send_stream(q, 1'b0);
    drain();
    // a write to an unused address must leave mode alone
    cfg_write(ADDR_SPARE, 32'h0000_0000);
    check_mode_reg();

    // random phases alternating between the two modes
    phase = 0;
    while (accepted < TARGET_ITEMS) begin
      drain();
      cfg_write(ADDR_MODE, (phase % 2 == 0) ? 32'(bsc_pkg::MODE_ENCODE)
                                            : 32'(bsc_pkg::MODE_DECODE));
      check_mode_reg();
      phase_start = accepted;
      if (phase == 0) begin
        // receiver holds off while bytes keep coming, so the input stalls
        hold_off = 1'b1;
        random_encode_stream(PRESSURE_LEN, 1'b1);
      end
      while (accepted - phase_start < 60 && accepted < TARGET_ITEMS) begin
        calm = ($urandom_range(0, 3) == 0);
        if (tracker.mode == bsc_pkg::MODE_ENCODE) begin
          random_encode_stream(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 9), calm);
        end else begin
          random_decode_stream(calm);
        end
        if ($urandom_range(0, 19) == 0) begin
          push <= 1'b0;
          @(posedge clk);
          while (tracker.pending() != 0) @(posedge clk);
        end
      end
      phase++;
    end

    drain();
    $display("covered %0d input transactions (%0d encode, %0d decode) over %0d mode phases",
             accepted, tracker.n_encode, tracker.n_decode, phase);
    $display("%0d inputs did work, checked %0d results, %0d of them stream-close only",
             counted, tracker.n_checked, tracker.n_closes);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
